FILE: rtl/sbsp_pkg.sv
// shared types, constants and helpers of the staged buffer slot pool
package sbsp_pkg;

    localparam int SLOTS       = 64;
    localparam int SLOT_W      = 6;
    localparam int CNT_W       = 7;
    localparam int STAGE_W     = 3;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(SLOTS);

    localparam logic [STAGE_W-1:0] ST_FREE      = 3'd0;
    localparam logic [STAGE_W-1:0] ST_DECODE    = 3'd1;
    localparam logic [STAGE_W-1:0] ST_SERIALIZE = 3'd5;

    typedef enum logic [CMD_W-1:0] {
        OP_ACQUIRE = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_RELEASE = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_BAD_INDEX = 2'd2,
        STATUS_BAD_MOVE  = 2'd3
    } status_t;

    typedef enum logic {
        BACK_IDLE = 1'b0,
        BACK_EXEC = 1'b1
    } back_state_t;

    typedef struct packed {
        op_t                 op;
        logic [SLOT_W-1:0]   slot;
        logic [STAGE_W-1:0]  next_stage;
        logic                in_range;
    } item_t;

    function automatic logic [CNT_W-1:0] eff_capacity(input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] r;
        begin
            r = cap;
            if (cap == '0)
                r = CNT_W'(1);
            else if (cap > CNT_W'(SLOTS))
                r = CNT_W'(SLOTS);
            return r;
        end
    endfunction

endpackage

FILE: rtl/sbsp_if.sv
// request and response channel interfaces

interface sbsp_req_if import sbsp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [SLOT_W-1:0]   slot;
    logic [STAGE_W-1:0]  next_stage;

    modport source (output valid, command, slot, next_stage, input ready);
    modport sink   (input valid, command, slot, next_stage, output ready);
endinterface

interface sbsp_rsp_if import sbsp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    granted_slot;
    logic [STAGE_W-1:0]   slot_stage;
    logic [CNT_W-1:0]     busy_count;
    logic [CNT_W-1:0]     high_water;
    logic                 none_busy;

    modport source (output valid, status, granted_slot, slot_stage, busy_count,
                    high_water, none_busy, input ready);
    modport sink   (input valid, status, granted_slot, slot_stage, busy_count,
                    high_water, none_busy, output ready);
endinterface

FILE: rtl/sbsp_ram.sv
// generic single write port, single read port ram with registered read
module sbsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/sbsp_front.sv
// front end: takes requests, decodes the command and checks the slot range
module sbsp_front import sbsp_pkg::*; (
    sbsp_req_if.sink          req,
    input  logic [CNT_W-1:0]  eff_cap,
    input  logic              full,
    output logic              push,
    output item_t             push_data
);

    always_comb
    begin
        req.ready = !full;
        push      = req.valid && !full;

        push_data.op         = op_t'(req.command);
        push_data.slot       = req.slot;
        push_data.next_stage = req.next_stage;
        push_data.in_range   = {1'b0, req.slot} < eff_cap;
    end

endmodule

FILE: rtl/sbsp_fifo.sv
// short queue between front and back ends
module sbsp_fifo import sbsp_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  item_t  push_data,
    output logic   full,
    input  logic   pop,
    output item_t  pop_data,
    output logic   empty
);

    item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    always_comb
    begin
        full        = count_reg == QCNT_W'(QUEUE_DEPTH);
        empty       = count_reg == '0;
        pop_data    = entry_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/sbsp_back.sv
// back end: slot stage store, busy map, counters and response register
module sbsp_back import sbsp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  eff_cap,
    input  logic              empty,
    input  item_t             pop_data,
    output logic              pop,
    sbsp_rsp_if.source        rsp
);

    back_state_t          state_reg;
    back_state_t          state_next;
    item_t                cmd_reg;
    item_t                cmd_next;
    logic [SLOTS-1:0]     busy_reg;
    logic [SLOTS-1:0]     busy_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     peak_reg;
    logic [CNT_W-1:0]     peak_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    status_t              status_reg;
    status_t              status_next;
    logic [SLOT_W-1:0]    granted_reg;
    logic [SLOT_W-1:0]    granted_next;
    logic [STAGE_W-1:0]   stage_reg;
    logic [STAGE_W-1:0]   stage_next;
    logic [CNT_W-1:0]     out_count_reg;
    logic [CNT_W-1:0]     out_count_next;
    logic [CNT_W-1:0]     out_peak_reg;
    logic [CNT_W-1:0]     out_peak_next;
    logic                 out_free_reg;
    logic                 out_free_next;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [STAGE_W-1:0]   ram_wdata;
    logic [STAGE_W-1:0]   ram_rdata;
    logic [STAGE_W-1:0]   cur_stage;
    logic                 grant_found;
    logic [SLOT_W-1:0]    grant_idx;
    logic                 exec_go;

    sbsp_ram #(
        .WIDTH (STAGE_W),
        .DEPTH (SLOTS)
    ) u_stage_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (pop),
        .raddr (pop_data.slot),
        .rdata (ram_rdata)
    );

    // lowest free slot below capacity
    always_comb
    begin
        grant_found = 1'b0;
        grant_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i] && (CNT_W'(i) < eff_cap))
            begin
                grant_found = 1'b1;
                grant_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        busy_next      = busy_reg;
        count_next     = count_reg;
        peak_next      = peak_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        granted_next   = granted_reg;
        stage_next     = stage_reg;
        out_count_next = out_count_reg;
        out_peak_next  = out_peak_reg;
        out_free_next  = out_free_reg;
        ram_we         = 1'b0;
        ram_waddr      = cmd_reg.slot;
        ram_wdata      = cmd_reg.next_stage;
        pop            = 1'b0;
        exec_go        = 1'b0;
        cur_stage      = busy_reg[cmd_reg.slot] ? ram_rdata : ST_FREE;

        case (state_reg)
            BACK_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = pop_data;
                    state_next = BACK_EXEC;
                end
            end
            BACK_EXEC:
            begin
                exec_go = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase

        if (exec_go)
        begin
            state_next     = BACK_IDLE;
            out_valid_next = 1'b1;
            status_next    = STATUS_OK;
            granted_next   = '0;
            stage_next     = ST_FREE;

            case (cmd_reg.op)
                OP_ACQUIRE:
                begin
                    if (grant_found)
                    begin
                        ram_we               = 1'b1;
                        ram_waddr            = grant_idx;
                        ram_wdata            = ST_DECODE;
                        busy_next[grant_idx] = 1'b1;
                        count_next           = count_reg + 1'b1;
                        if (count_next > peak_reg)
                        begin
                            peak_next = count_next;
                        end
                        granted_next = grant_idx;
                        stage_next   = ST_DECODE;
                    end
                    else
                    begin
                        status_next = STATUS_EXHAUSTED;
                    end
                end
                OP_RELEASE:
                begin
                    if (cmd_reg.in_range && busy_reg[cmd_reg.slot])
                    begin
                        busy_next[cmd_reg.slot] = 1'b0;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                OP_ADVANCE:
                begin
                    if (!cmd_reg.in_range)
                    begin
                        status_next = STATUS_BAD_INDEX;
                    end
                    else if (cur_stage == ST_FREE || cur_stage >= ST_SERIALIZE ||
                             cmd_reg.next_stage != cur_stage + 3'd1)
                    begin
                        status_next = STATUS_BAD_MOVE;
                        stage_next  = cur_stage;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        stage_next = cmd_reg.next_stage;
                    end
                end
                OP_READ:
                begin
                    if (!cmd_reg.in_range)
                    begin
                        status_next = STATUS_BAD_INDEX;
                    end
                    else
                    begin
                        stage_next = cur_stage;
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase

            out_count_next = count_next;
            out_peak_next  = peak_next;
            out_free_next  = count_next == '0;
        end

        rsp.valid        = out_valid_reg;
        rsp.status       = status_reg;
        rsp.granted_slot = granted_reg;
        rsp.slot_stage   = stage_reg;
        rsp.busy_count   = out_count_reg;
        rsp.high_water   = out_peak_reg;
        rsp.none_busy    = out_free_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            busy_reg      <= '0;
            count_reg     <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        stage_reg     <= stage_next;
        out_count_reg <= out_count_next;
        out_peak_reg  <= out_peak_next;
        out_free_reg  <= out_free_next;
    end

endmodule

FILE: rtl/staged_buffer_slot_pool_top.sv
// top level of the staged buffer slot pool
// a request passes through the queue, the command register and then the response register
// the back end takes a new request only when done with the last, as each reads then updates the stage ram
// a 2-entry queue lets requests be taken while the back end or the response side stalls
// reset: all slots free via the cleared busy map, counters zero, capacity 64, no clearing pass
module staged_buffer_slot_pool_top import sbsp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              capacity_we,
    input  logic [CNT_W-1:0]  capacity_wdata,
    sbsp_req_if.sink          req,
    sbsp_rsp_if.source        rsp
);

    logic [CNT_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  capacity_next;
    logic [CNT_W-1:0]  eff_cap;
    logic              q_push;
    item_t             q_push_data;
    logic              q_full;
    logic              q_pop;
    item_t             q_pop_data;
    logic              q_empty;

    always_comb
    begin
        capacity_next = capacity_we ? capacity_wdata : capacity_reg;
        eff_cap       = eff_capacity(capacity_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    sbsp_front u_front (
        .req       (req),
        .eff_cap   (eff_cap),
        .full      (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    sbsp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    sbsp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .eff_cap  (eff_cap),
        .empty    (q_empty),
        .pop_data (q_pop_data),
        .pop      (q_pop),
        .rsp      (rsp)
    );

endmodule
